/* rtl/ppsm_pkg.sv */
// ----------------------------------------------------------------------------
// ppsm_pkg
// Shared types and constants of the pulse period speed meter.
// ----------------------------------------------------------------------------
`default_nettype none

package ppsm_pkg;

  localparam int TIME_W    = 32;
  localparam int FRAC_BITS = 8;
  localparam int SPEED_W   = 24;
  localparam int CENTI_W   = 16;
  localparam int CIRC_W    = 10;
  localparam int PPR_W     = 7;
  localparam int TMO_W     = 26;
  localparam int WGT_W     = 4;
  localparam int PROD_W    = 32;
  localparam int DIV_W     = PROD_W + FRAC_BITS;
  localparam int DEN_W     = PPR_W + TIME_W;
  localparam int ACC_W     = SPEED_W + WGT_W;
  localparam int CNT_W     = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = CENTI_W + 2 * TIME_W;
  localparam int RECIP_W     = 32;
  localparam int SCALE_W     = ACC_W + RECIP_W;
  localparam int RECIP_SHIFT = 35;

  localparam logic [PROD_W-1:0] CENTI_KMH_PER_CM_US = PROD_W'(3600000);
  localparam logic [WGT_W-1:0]  WEIGHT_FULL         = WGT_W'(10);
  localparam logic [ACC_W-1:0]  ROUND_HALF          = ACC_W'(5);
  localparam logic [RECIP_W-1:0] RECIP_TEN          = 32'hCCCC_CCCD;

  localparam logic [CIRC_W-1:0] CIRC_RESET = CIRC_W'(200);
  localparam logic [PPR_W-1:0]  PPR_RESET  = PPR_W'(1);
  localparam logic [TMO_W-1:0]  TMO_RESET  = TMO_W'(2000000);
  localparam logic [WGT_W-1:0]  WGT_RESET  = WGT_W'(7);

  localparam logic [CFG_IDX_W-1:0] REG_CIRC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PPR  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TMO  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_WGT  = CFG_IDX_W'(3);

  localparam logic CMD_PULSE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic [CIRC_W-1:0] circumference_cm;
    logic [PPR_W-1:0]  pulses_per_rev;
    logic [TMO_W-1:0]  stop_timeout_us;
    logic [WGT_W-1:0]  new_weight_tenths;
  } cfg_regs_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

/* rtl/ppsm_cfg.sv */
// ----------------------------------------------------------------------------
// ppsm_cfg
// Configuration register file; clamps pulses per revolution and filter weight.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsm_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ppsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ppsm_pkg::TMO_W-1:0]        cfg_data,
  output ppsm_pkg::cfg_regs_t                    regs
);

  logic [ppsm_pkg::PPR_W-1:0] ppr_in;
  logic [ppsm_pkg::WGT_W-1:0] wgt_in;

  assign cfg_ready = 1'b1;

  always_comb begin
    ppr_in = cfg_data[ppsm_pkg::PPR_W-1:0];
    if (ppr_in == '0) begin
      ppr_in = ppsm_pkg::PPR_W'(1);
    end
    wgt_in = cfg_data[ppsm_pkg::WGT_W-1:0];
    if (wgt_in > ppsm_pkg::WEIGHT_FULL) begin
      wgt_in = ppsm_pkg::WEIGHT_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.circumference_cm  <= ppsm_pkg::CIRC_RESET;
      regs.pulses_per_rev    <= ppsm_pkg::PPR_RESET;
      regs.stop_timeout_us   <= ppsm_pkg::TMO_RESET;
      regs.new_weight_tenths <= ppsm_pkg::WGT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppsm_pkg::REG_CIRC: regs.circumference_cm  <= cfg_data[ppsm_pkg::CIRC_W-1:0];
        ppsm_pkg::REG_PPR:  regs.pulses_per_rev    <= ppr_in;
        ppsm_pkg::REG_TMO:  regs.stop_timeout_us   <= cfg_data;
        ppsm_pkg::REG_WGT:  regs.new_weight_tenths <= wgt_in;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/ppsm_div.sv */
// ----------------------------------------------------------------------------
// ppsm_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsm_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ppsm_pkg::DIV_W-1:0]    dividend,
  input  wire logic [ppsm_pkg::DIV_W-1:0]    divisor,
  output logic [ppsm_pkg::DIV_W-1:0]         quotient,
  output ppsm_pkg::div_sts_t                 sts
);

  logic [ppsm_pkg::DIV_W-1:0] rem;
  logic [ppsm_pkg::DIV_W-1:0] dsr;
  logic [ppsm_pkg::CNT_W-1:0] cnt;
  logic [ppsm_pkg::DIV_W:0]   trial;
  logic [ppsm_pkg::DIV_W:0]   diff;
  logic                       fits;

  always_comb begin
    trial = {rem, quotient[ppsm_pkg::DIV_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = !diff[ppsm_pkg::DIV_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sts.busy <= 1'b0;
      sts.done <= 1'b0;
      cnt      <= '0;
    end else begin
      sts.done <= sts.busy && !start && (cnt == ppsm_pkg::CNT_W'(1));
      if (start) begin
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
        cnt      <= ppsm_pkg::CNT_W'(ppsm_pkg::DIV_W);
        sts.busy <= 1'b1;
      end else if (sts.busy) begin
        rem      <= fits ? diff[ppsm_pkg::DIV_W-1:0] : trial[ppsm_pkg::DIV_W-1:0];
        quotient <= {quotient[ppsm_pkg::DIV_W-2:0], fits};
        cnt      <= cnt - ppsm_pkg::CNT_W'(1);
        if (cnt == ppsm_pkg::CNT_W'(1)) begin
          sts.busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/pulse_period_speed_meter.sv */
// ----------------------------------------------------------------------------
// pulse_period_speed_meter
// Period tachometer: pulse intervals, stop timeout, speed division and
// an exponentially weighted moving average, run by a sequencer over one serial divider.
// ----------------------------------------------------------------------------
// Pulse item: taken while idle with no result; the input stays ready for the next item.
// Sample item: on stop or an invalid interval the sequencer goes from check
// to output; when the speed is computed it passes once through the serial
// divider and the filter, plus any wait for the output register to drain.
// Sample result appears in the output register the cycle the sequencer ends.
// Synchronous reset clears control and speed state, restores register defaults.
`default_nettype none

module pulse_period_speed_meter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [ppsm_pkg::TIME_W-1:0]         s_tdata,   // timestamp_us
  input  wire logic                                s_tuser,   // command
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [ppsm_pkg::OUT_W-1:0]               m_tdata,   // speed_centi_kmh,
                                                              // pulse_total, interval_us
  output logic                                     m_tuser,   // stopped
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ppsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ppsm_pkg::TMO_W-1:0]          cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_MUL, S_DRAW, S_FILT, S_DFILT, S_OUT
  } state_t;

  state_t state;

  ppsm_pkg::cfg_regs_t regs;
  ppsm_pkg::div_sts_t  div_sts;

  logic [ppsm_pkg::TIME_W-1:0]  last_pulse_time;
  logic [ppsm_pkg::TIME_W-1:0]  pulse_interval;
  logic [ppsm_pkg::TIME_W-1:0]  pulse_counter;
  logic [ppsm_pkg::SPEED_W-1:0] current_speed;
  logic [ppsm_pkg::SPEED_W-1:0] filter_memory;
  logic [ppsm_pkg::TIME_W-1:0]  now;
  logic                         stopped;
  logic [ppsm_pkg::ACC_W-1:0]   acc;
  logic                         div_start;
  logic [ppsm_pkg::DIV_W-1:0]   div_a;
  logic [ppsm_pkg::DIV_W-1:0]   div_b;
  logic [ppsm_pkg::DIV_W-1:0]   quotient;

  logic [ppsm_pkg::TIME_W-1:0]  elapsed;
  logic [ppsm_pkg::TIME_W-1:0]  timeout_ext;
  logic [ppsm_pkg::PROD_W-1:0]  num_prod;
  logic [ppsm_pkg::DEN_W-1:0]   den_prod;
  logic [ppsm_pkg::SPEED_W-1:0] q_sat;
  logic [ppsm_pkg::ACC_W-1:0]   blend;
  logic [ppsm_pkg::SCALE_W-1:0] scaled;

  ppsm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  ppsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (quotient),
    .sts      (div_sts)
  );

  assign s_tready = (state == S_IDLE);

  always_comb begin
    elapsed     = now - last_pulse_time;
    timeout_ext = ppsm_pkg::TIME_W'(regs.stop_timeout_us);
    num_prod    = ppsm_pkg::PROD_W'(regs.circumference_cm) * ppsm_pkg::CENTI_KMH_PER_CM_US;
    den_prod    = ppsm_pkg::DEN_W'(regs.pulses_per_rev) * ppsm_pkg::DEN_W'(pulse_interval);
    if (|quotient[ppsm_pkg::DIV_W-1:ppsm_pkg::SPEED_W]) begin
      q_sat = '1;
    end else begin
      q_sat = quotient[ppsm_pkg::SPEED_W-1:0];
    end
    blend = ppsm_pkg::ACC_W'(ppsm_pkg::WEIGHT_FULL - regs.new_weight_tenths)
            * ppsm_pkg::ACC_W'(filter_memory) + acc + ppsm_pkg::ROUND_HALF;
    scaled = ppsm_pkg::SCALE_W'(acc) * ppsm_pkg::SCALE_W'(ppsm_pkg::RECIP_TEN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      div_start       <= 1'b0;
      last_pulse_time <= '0;
      pulse_interval  <= '0;
      pulse_counter   <= '0;
      current_speed   <= '0;
      filter_memory   <= '0;
    end else begin
      div_start <= (state == S_MUL);
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == ppsm_pkg::CMD_PULSE) begin
              pulse_interval  <= s_tdata - last_pulse_time;
              last_pulse_time <= s_tdata;
              pulse_counter   <= pulse_counter + ppsm_pkg::TIME_W'(1);
            end else begin
              now   <= s_tdata;
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          stopped <= (elapsed > timeout_ext);
          if (elapsed > timeout_ext) begin
            current_speed  <= '0;
            pulse_interval <= '0;
            state          <= S_OUT;
          end else if (pulse_interval != '0 && pulse_interval < timeout_ext) begin
            state <= S_MUL;
          end else begin
            state <= S_OUT;
          end
        end
        S_MUL: begin
          div_a <= {num_prod, {ppsm_pkg::FRAC_BITS{1'b0}}};
          div_b <= ppsm_pkg::DIV_W'(den_prod);
          state <= S_DRAW;
        end
        S_DRAW: begin
          if (div_sts.done) begin
            acc   <= ppsm_pkg::ACC_W'(regs.new_weight_tenths) * ppsm_pkg::ACC_W'(q_sat);
            state <= S_FILT;
          end
        end
        S_FILT: begin
          acc   <= blend;
          state <= S_DFILT;
        end
        S_DFILT: begin
          current_speed <= scaled[ppsm_pkg::RECIP_SHIFT +: ppsm_pkg::SPEED_W];
          filter_memory <= scaled[ppsm_pkg::RECIP_SHIFT +: ppsm_pkg::SPEED_W];
          state         <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {pulse_interval, pulse_counter,
                         current_speed[ppsm_pkg::SPEED_W-1:ppsm_pkg::FRAC_BITS]};
            m_tuser  <= stopped;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> state == S_DRAW)
    else $error("divider result outside a wait state");

  a_pulse_count: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == ppsm_pkg::CMD_PULSE
    |=> pulse_counter == $past(pulse_counter) + ppsm_pkg::TIME_W'(1))
    else $error("pulse item not counted");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) && m_tuser |-> m_tdata[ppsm_pkg::CENTI_W-1:0] == '0
      && m_tdata[ppsm_pkg::OUT_W-1:ppsm_pkg::OUT_W-ppsm_pkg::TIME_W] == '0)
    else $error("stopped result with nonzero speed or interval");

endmodule

`default_nettype wire
